// ===== hw/rtl/tdpt_pkg.sv =====
// Shared constants, command and status types for the trial-division prime tester.
package tdpt_pkg;

    localparam int VALUE_BITS = 31;
    localparam int ROOT_DEPTH = 65536;

    // Sieve index width and the width of counters that must step past the top entry
    localparam int IDX_W  = $clog2(ROOT_DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int SQ_W   = 2 * CNT_W;

    // Root of a VALUE_BITS number; candidate padded to whole bit pairs
    localparam int ROOT_W = (VALUE_BITS + 1) / 2;
    localparam int DIV_W  = 2 * ROOT_W;
    localparam int STEP_W = $clog2(ROOT_W + 1);

    localparam int LIM_W  = (ROOT_W > IDX_W) ? ROOT_W : IDX_W;
    localparam logic [LIM_W-1:0] ROOT_LIMIT = LIM_W'(ROOT_DEPTH - 1);

    localparam int S_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_CLEAR,
        ST_READ,
        ST_CHECK,
        ST_REM,
        ST_MARK,
        ST_FINISH
    } tdpt_state_t;

    typedef struct packed {
        logic load;        // capture candidate, start the root unit
        logic root_take;   // latch the saturated root, aim the clear pointer at 2
        logic clr_step;    // clear the entry under the pointer, advance
        logic walk_start;  // set the walk index to 2
        logic rd;          // read the sieve entry at the walk index
        logic i_next;      // advance the walk index
        logic rem_start;   // start the remainder unit on the walk index
        logic div_found;   // record a divisor: verdict is not prime
        logic mark_start;  // aim the mark pointer at the square of the walk index
        logic mark_step;   // mark the entry under the pointer, advance by the index
        logic res_load;    // move the verdict into the output register
    } tdpt_cmd_t;

    typedef struct packed {
        logic root_busy;
        logic clr_end;
        logic walk_end;
        logic marked;
        logic rem_busy;
        logic rem_zero;
        logic mark_skip;
        logic mark_end;
        logic out_free;
    } tdpt_stat_t;

endpackage

// ===== hw/rtl/trial_division_prime_test.sv =====
// Top level of the trial-division prime tester: stream ports, controller and datapath.
//
// One word in, one word out. Each candidate (31 bits, unsigned) is answered
// with is_prime, which is 0 for zero, one and every composite. The work is
// sequential, one candidate at a time: the root phase finds the exact square
// root r in the root unit and latches it, saturated at 65535, a clearing pass
// writes the sieve entries 2..r at one per cycle, then the walk reads each
// index in the READ and CHECK states (registered sieve read), runs the
// two-bit-per-cycle remainder unit for each unmarked index, and marks that
// index's multiples. Multiples are marked from i*i upwards, which leaves the
// same entries unmarked at the time they are read. A divisor ends the walk
// at once. The run time is bound by the single sieve port and the remainder
// unit. A finished result sits in the output register while the next word
// is taken in.
module trial_division_prime_test
    import tdpt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [30:0] candidate, [31] zero fill
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [0] is_prime, [7:1] zero fill
);

    tdpt_cmd_t  cmd;
    tdpt_stat_t stat;
    logic       is_prime;

    // Sequence the phases; take a word only when idle
    tdpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the sieve, the arithmetic units and the output register
    tdpt_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .candidate (s_tdata[VALUE_BITS-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .is_prime  (is_prime)
    );

    assign m_tdata = M_TDATA_W'(is_prime);

endmodule

// ===== hw/rtl/tdpt_isqrt.sv =====
// Iterative integer square root, one bit of the root per cycle.
module tdpt_isqrt
    import tdpt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  busy,
    output logic [ROOT_W-1:0]     root
);

    localparam int REM_W = ROOT_W + 2;

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]    val_reg, val_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [REM_W+1:0]    cur, trial;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cur       = {rem_reg, val_reg[DIV_W-1 -: 2]};
        trial     = {REM_W'(root_reg), 2'b01};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(ROOT_W);
            val_next  = DIV_W'(value);
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            val_next = {val_reg[DIV_W-3:0], 2'b00};
            if (cur >= trial) begin
                rem_next  = REM_W'(cur - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = REM_W'(cur);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ===== hw/rtl/tdpt_rem.sv =====
// Restoring remainder unit, two dividend bits per cycle.
module tdpt_rem
    import tdpt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [IDX_W-1:0]  divisor,
    output logic              busy,
    output logic              zero
);

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [IDX_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]    div_reg, div_next;
    logic [IDX_W:0]      t1, t2, d_ext;
    logic [IDX_W-1:0]    r1;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        d_ext     = {1'b0, div_reg};
        t1        = {rem_reg, quo_reg[DIV_W-1]};
        r1        = (t1 >= d_ext) ? IDX_W'(t1 - d_ext) : IDX_W'(t1);
        t2        = {r1, quo_reg[DIV_W-2]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(ROOT_W);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_W-3:0], 2'b00};
            rem_next = (t2 >= d_ext) ? IDX_W'(t2 - d_ext) : IDX_W'(t2);
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy = busy_reg;
    assign zero = (rem_reg == '0);

endmodule

// ===== hw/rtl/tdpt_datapath.sv =====
// Datapath: candidate and root registers, walk and mark pointers, sieve memory, result register.
module tdpt_datapath
    import tdpt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [VALUE_BITS-1:0] candidate,
    input  tdpt_cmd_t             cmd,
    output tdpt_stat_t            stat,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic                  is_prime
);

    logic [VALUE_BITS-1:0] cand_reg;
    logic [IDX_W-1:0]      r_reg;
    logic [CNT_W-1:0]      i_reg;
    logic [CNT_W-1:0]      j_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic                  verdict_reg;
    logic                  out_valid_reg;
    logic                  out_prime_reg;
    logic                  rd_bit_reg;

    logic                  sieve_mem [ROOT_DEPTH];

    logic                  root_busy;
    logic [ROOT_W-1:0]     root;
    logic [LIM_W-1:0]      root_ext;
    logic [IDX_W-1:0]      root_sat;
    logic [CNT_W-1:0]      r_ext;
    logic                  rem_busy;
    logic                  rem_zero;
    logic                  sieve_we;

    tdpt_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.load),
        .value   (candidate),
        .busy    (root_busy),
        .root    (root)
    );

    tdpt_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.rem_start),
        .dividend (DIV_W'(cand_reg)),
        .divisor  (i_reg[IDX_W-1:0]),
        .busy     (rem_busy),
        .zero     (rem_zero)
    );

    // Saturate the root at the top of the sieve
    assign root_ext = LIM_W'(root);
    assign root_sat = (root_ext > ROOT_LIMIT) ? ROOT_LIMIT[IDX_W-1:0] : root_ext[IDX_W-1:0];
    assign r_ext    = {1'b0, r_reg};
    assign sieve_we = cmd.clr_step | cmd.mark_step;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cand_reg    <= candidate;
            verdict_reg <= (candidate > VALUE_BITS'(1));
        end else if (cmd.div_found) begin
            verdict_reg <= 1'b0;
        end
        if (cmd.root_take) begin
            r_reg <= root_sat;
        end
        if (cmd.walk_start) begin
            i_reg <= CNT_W'(2);
        end else if (cmd.i_next) begin
            i_reg <= i_reg + CNT_W'(1);
        end
        if (cmd.root_take) begin
            j_reg <= CNT_W'(2);
        end else if (cmd.clr_step) begin
            j_reg <= j_reg + CNT_W'(1);
        end else if (cmd.mark_start) begin
            j_reg <= sq_reg[CNT_W-1:0];
        end else if (cmd.mark_step) begin
            j_reg <= j_reg + i_reg;
        end
        sq_reg <= i_reg * i_reg;
    end

    // Sieve memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (sieve_we) begin
            sieve_mem[j_reg[IDX_W-1:0]] <= cmd.mark_step;
        end
        if (cmd.rd) begin
            rd_bit_reg <= sieve_mem[i_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.res_load) begin
            out_prime_reg <= verdict_reg;
        end
    end

    always_comb begin
        stat.root_busy = root_busy;
        stat.clr_end   = (j_reg > r_ext);
        stat.walk_end  = (i_reg > r_ext);
        stat.marked    = rd_bit_reg;
        stat.rem_busy  = rem_busy;
        stat.rem_zero  = rem_zero;
        stat.mark_skip = (sq_reg > SQ_W'(r_reg));
        stat.mark_end  = (j_reg > r_ext);
        stat.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign is_prime = out_prime_reg;

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sieve_we |-> (j_reg <= r_ext) && (j_reg >= CNT_W'(2)))
        else $error("sieve write outside 2..r");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");

    a_rem_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rem_start |=> rem_busy)
        else $error("remainder unit did not start");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(cmd.res_load))
        else $error("result valid without a load");

endmodule

// ===== hw/rtl/tdpt_ctrl.sv =====
// Controller state machine sequencing root, clear, walk, remainder and mark phases.
module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  tdpt_stat_t stat,
    output tdpt_cmd_t  cmd
);

    tdpt_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (!stat.root_busy) begin
                    cmd.root_take = 1'b1;
                    state_next    = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (stat.clr_end) begin
                    cmd.walk_start = 1'b1;
                    state_next     = ST_READ;
                end else begin
                    cmd.clr_step = 1'b1;
                end
            end
            ST_READ: begin
                if (stat.walk_end) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.marked) begin
                    cmd.i_next = 1'b1;
                    state_next = ST_READ;
                end else begin
                    cmd.rem_start = 1'b1;
                    state_next    = ST_REM;
                end
            end
            ST_REM: begin
                if (!stat.rem_busy) begin
                    if (stat.rem_zero) begin
                        cmd.div_found = 1'b1;
                        state_next    = ST_FINISH;
                    end else if (stat.mark_skip) begin
                        cmd.i_next = 1'b1;
                        state_next = ST_READ;
                    end else begin
                        cmd.mark_start = 1'b1;
                        state_next     = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                if (stat.mark_end) begin
                    cmd.i_next = 1'b1;
                    state_next = ST_READ;
                end else begin
                    cmd.mark_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
